// ----- rtl/ttw_pkg.sv -----
`default_nettype none
package ttw_pkg;

	localparam int unsigned IndexWidth = 16;
	localparam int unsigned CoordWidth = 32;
	localparam int unsigned TanWidth = 48;
	localparam int unsigned DeltaWidth = 33;
	localparam int unsigned NumWidth = 67;
	localparam int unsigned MagWidth = 66;
	localparam int unsigned DetWidth = 64;
	localparam int unsigned QuoWidth = 82;
	localparam int unsigned EpsWidth = 32;
	localparam int unsigned ScaleWidth = 20;
	localparam int unsigned CfgIdxWidth = 1;

	localparam logic [CfgIdxWidth-1:0] RegDetEpsilon = 1'b0;
	localparam logic [CfgIdxWidth-1:0] RegFallbackScale = 1'b1;

	localparam logic [EpsWidth-1:0] EpsReset = 32'd512;
	localparam logic [ScaleWidth-1:0] ScaleReset = 20'd100000;
	localparam logic [TanWidth-1:0] UnitTangent = 48'd65536;
	localparam logic [TanWidth:0] PosLimit = 49'h0_7FFF_FFFF_FFFF;
	localparam logic [TanWidth:0] NegLimit = 49'h0_8000_0000_0000;

	typedef struct packed {
		logic [IndexWidth-1:0] idx0;
		logic [IndexWidth-1:0] idx1;
		logic [IndexWidth-1:0] idx2;
		logic signed [DeltaWidth-1:0] e1x, e1y, e1z;
		logic signed [DeltaWidth-1:0] e2x, e2y, e2z;
		logic signed [DeltaWidth-1:0] du1, dv1, du2, dv2;
	} tri_job_t;

	typedef enum logic [2:0] {
		BkIdle, BkDet, BkNum, BkDiv, BkSat, BkEmit
	} bk_state_t;

endpackage
`default_nettype wire

// ----- rtl/ttw_if.sv -----
`default_nettype none
interface ttw_corner_if;
	logic valid;
	logic ready;
	logic start_req;
	logic [ttw_pkg::IndexWidth-1:0] vertex_index;
	logic signed [ttw_pkg::CoordWidth-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;
	modport source (output valid, start_req, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
		input ready);
	modport sink (input valid, start_req, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
		output ready);
endinterface

interface ttw_write_if;
	logic valid;
	logic ready;
	logic [ttw_pkg::IndexWidth-1:0] target_index;
	logic signed [ttw_pkg::TanWidth-1:0] tangent_x, tangent_y, tangent_z;
	logic saturated;
	logic last_write;
	modport source (output valid, target_index, tangent_x, tangent_y, tangent_z, saturated,
		last_write, input ready);
	modport sink (input valid, target_index, tangent_x, tangent_y, tangent_z, saturated,
		last_write, output ready);
endinterface

interface ttw_cfg_if;
	logic valid;
	logic ready;
	logic [ttw_pkg::CfgIdxWidth-1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ttw_front.sv -----
`default_nettype none
// Holds the first two corners and forms deltas on the third.
module ttw_front (
	input wire logic clk,
	input wire logic arst_n,
	ttw_corner_if.sink corner,
	output logic job_valid,
	input wire logic job_ready,
	output ttw_pkg::tri_job_t job
);
	logic [1:0] count_q;
	logic [ttw_pkg::IndexWidth-1:0] hidx_q [2];
	logic signed [ttw_pkg::CoordWidth-1:0] hpos_q [6];
	logic signed [ttw_pkg::CoordWidth-1:0] htex_q [4];
	logic [1:0] cur;
	logic third;
	logic acc;
	logic [2:0] pbase;

	assign cur = corner.start_req ? 2'd0 : count_q;
	assign third = (cur == 2'd2);
	assign corner.ready = !third || job_ready;
	assign job_valid = corner.valid && third;
	assign acc = corner.valid && corner.ready;
	// Positions of the second corner sit after the three of the first.
	assign pbase = cur[0] ? 3'd3 : 3'd0;

	function automatic logic signed [ttw_pkg::DeltaWidth-1:0] dif(
		input logic signed [ttw_pkg::CoordWidth-1:0] a,
		input logic signed [ttw_pkg::CoordWidth-1:0] b);
		return ttw_pkg::DeltaWidth'(a) - ttw_pkg::DeltaWidth'(b);
	endfunction

	always_comb begin
		job.idx0 = hidx_q[0];
		job.idx1 = hidx_q[1];
		job.idx2 = corner.vertex_index;
		job.e1x = dif(hpos_q[3], hpos_q[0]);
		job.e1y = dif(hpos_q[4], hpos_q[1]);
		job.e1z = dif(hpos_q[5], hpos_q[2]);
		job.e2x = dif(corner.pos_x, hpos_q[0]);
		job.e2y = dif(corner.pos_y, hpos_q[1]);
		job.e2z = dif(corner.pos_z, hpos_q[2]);
		job.du1 = dif(htex_q[2], htex_q[0]);
		job.dv1 = dif(htex_q[3], htex_q[1]);
		job.du2 = dif(corner.tex_u, htex_q[0]);
		job.dv2 = dif(corner.tex_v, htex_q[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			hidx_q <= '{default: '0};
			hpos_q <= '{default: '0};
			htex_q <= '{default: '0};
		end else if (acc) begin
			if (third) begin
				count_q <= 2'd0;
			end else begin
				count_q <= cur + 2'd1;
				hidx_q[cur[0]] <= corner.vertex_index;
				hpos_q[pbase] <= corner.pos_x;
				hpos_q[pbase + 3'd1] <= corner.pos_y;
				hpos_q[pbase + 3'd2] <= corner.pos_z;
				htex_q[{cur[0], 1'b0}] <= corner.tex_u;
				htex_q[{cur[0], 1'b1}] <= corner.tex_v;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("corner count out of range");
	a_job_third: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> corner.valid) else $error("job without corner");
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && third) |=> count_q == 2'd0) else $error("count did not wrap");
endmodule
`default_nettype wire

// ----- rtl/ttw_queue.sv -----
`default_nettype none
// Two-entry job queue between front and back.
module ttw_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ttw_pkg::tri_job_t in_job,
	output logic out_valid,
	input wire logic out_ready,
	output ttw_pkg::tri_job_t out_job
);
	ttw_pkg::tri_job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer mismatch");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("count slip");
endmodule
`default_nettype wire

// ----- rtl/ttw_back.sv -----
`default_nettype none
// Determinant, numerators, shared restoring divider or fallback scaling, saturation, three writes.
module ttw_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input wire ttw_pkg::tri_job_t job,
	input wire logic [ttw_pkg::EpsWidth-1:0] det_epsilon,
	input wire logic [ttw_pkg::ScaleWidth-1:0] fallback_scale,
	ttw_write_if.source wr
);
	localparam int unsigned MW = ttw_pkg::MagWidth;
	localparam int unsigned QW = ttw_pkg::QuoWidth;
	localparam int unsigned TW = ttw_pkg::TanWidth;

	ttw_pkg::bk_state_t st_q, st_d;
	ttw_pkg::tri_job_t job_q;
	logic [1:0] comp_q;
	logic [6:0] bit_q;
	logic [1:0] wr_q;
	logic signed [ttw_pkg::NumWidth-1:0] p1_q, p2_q;
	logic det_neg_q, inv_q;
	logic [ttw_pkg::DetWidth-1:0] det_mag_q;
	logic num_neg_q;
	logic [QW-1:0] dvd_q;
	logic [ttw_pkg::DetWidth:0] rem_q;
	logic [QW-1:0] res_q;
	logic [TW-1:0] tan_q [3];
	logic flag_q;
	logic [1:0] ph_q;

	logic signed [ttw_pkg::DeltaWidth-1:0] ea, eb;
	logic signed [ttw_pkg::NumWidth:0] diff;
	logic dneg;
	logic [MW:0] dmag;
	logic [ttw_pkg::DetWidth:0] rsh;
	logic rge;
	logic [MW+ttw_pkg::ScaleWidth-1:0] fprod;
	logic sneg;
	logic [TW:0] lim;
	logic big;
	logic [TW-1:0] sval;

	assign job_ready = (st_q == ttw_pkg::BkIdle);

	always_comb begin
		case (comp_q)
			2'd0: begin ea = job_q.e1x; eb = job_q.e2x; end
			2'd1: begin ea = job_q.e1y; eb = job_q.e2y; end
			default: begin ea = job_q.e1z; eb = job_q.e2z; end
		endcase
		diff = (ttw_pkg::NumWidth+1)'(p1_q) - (ttw_pkg::NumWidth+1)'(p2_q);
		dneg = diff[ttw_pkg::NumWidth];
		dmag = dneg ? (MW+1)'(-diff) : (MW+1)'(diff);
		rsh = {rem_q[ttw_pkg::DetWidth-1:0], dvd_q[QW-1]};
		rge = rsh >= {1'b0, det_mag_q};
		fprod = MW'(dmag) * (MW+ttw_pkg::ScaleWidth)'(fallback_scale);
		sneg = num_neg_q && (res_q != '0);
		lim = sneg ? ttw_pkg::NegLimit : ttw_pkg::PosLimit;
		big = (res_q[QW-1:TW+1] != '0) || (res_q[TW:0] > lim);
		sval = big ? lim[TW-1:0] : res_q[TW-1:0];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ttw_pkg::BkIdle: if (job_valid) st_d = ttw_pkg::BkDet;
			ttw_pkg::BkDet: if (ph_q == 2'd1) st_d = ttw_pkg::BkNum;
			ttw_pkg::BkNum: if (ph_q == 2'd1) st_d = ttw_pkg::BkDiv;
			ttw_pkg::BkDiv: if (!inv_q || bit_q == 7'd0) st_d = ttw_pkg::BkSat;
			ttw_pkg::BkSat: st_d = (comp_q == 2'd2) ? ttw_pkg::BkEmit : ttw_pkg::BkNum;
			ttw_pkg::BkEmit: if (wr.ready && wr_q == 2'd2) st_d = ttw_pkg::BkIdle;
			default: st_d = ttw_pkg::BkIdle;
		endcase
	end

	always_comb begin
		wr.valid = (st_q == ttw_pkg::BkEmit);
		case (wr_q)
			2'd0: wr.target_index = job_q.idx0;
			2'd1: wr.target_index = job_q.idx1;
			default: wr.target_index = job_q.idx2;
		endcase
		wr.last_write = (wr_q == 2'd2);
		if (tan_q[0] == '0 && tan_q[1] == '0 && tan_q[2] == '0) begin
			wr.tangent_x = ttw_pkg::UnitTangent;
			wr.saturated = 1'b0;
		end else begin
			wr.tangent_x = tan_q[0];
			wr.saturated = flag_q;
		end
		wr.tangent_y = tan_q[1];
		wr.tangent_z = tan_q[2];
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ttw_pkg::BkIdle: if (job_valid) job_q <= job;
			ttw_pkg::BkDet, ttw_pkg::BkNum: begin
				if (ph_q == 2'd0) begin
					if (st_q == ttw_pkg::BkDet) begin
						p1_q <= ttw_pkg::NumWidth'(job_q.du1 * job_q.dv2);
						p2_q <= ttw_pkg::NumWidth'(job_q.du2 * job_q.dv1);
					end else begin
						p1_q <= ttw_pkg::NumWidth'(job_q.dv2 * ea);
						p2_q <= ttw_pkg::NumWidth'(job_q.dv1 * eb);
					end
				end else if (st_q == ttw_pkg::BkDet) begin
					det_neg_q <= dneg;
					if (!dneg) det_mag_q <= (dmag > (MW+1)'(64'h7FFF_FFFF_FFFF_FFFF)) ?
						64'h7FFF_FFFF_FFFF_FFFF : dmag[63:0];
					else det_mag_q <= (dmag > (MW+1)'(64'h8000_0000_0000_0000)) ?
						64'h8000_0000_0000_0000 : dmag[63:0];
					inv_q <= ((dmag > (MW+1)'(64'h8000_0000_0000_0000)) ?
						1'b1 : (dmag > (MW+1)'(det_epsilon)));
				end else begin
					num_neg_q <= dneg;
					dvd_q <= {dmag[MW-1:0], 16'd0};
					rem_q <= '0;
					res_q <= QW'(fprod >> 16);
				end
			end
			ttw_pkg::BkDiv: if (inv_q) begin
				dvd_q <= {dvd_q[QW-2:0], 1'b0};
				rem_q <= rge ? rsh - {1'b0, det_mag_q} : rsh;
				res_q <= {res_q[QW-2:0], rge};
				if (bit_q == 7'd0) num_neg_q <= num_neg_q ^ det_neg_q;
			end
			ttw_pkg::BkSat: tan_q[comp_q] <= sneg ? -sval : sval;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ttw_pkg::BkIdle;
			ph_q <= 2'd0;
			comp_q <= 2'd0;
			bit_q <= 7'd0;
			wr_q <= 2'd0;
			flag_q <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ttw_pkg::BkIdle: begin
					comp_q <= 2'd0;
					wr_q <= 2'd0;
					flag_q <= 1'b0;
					ph_q <= 2'd0;
				end
				ttw_pkg::BkDet: ph_q <= (ph_q == 2'd1) ? 2'd0 : 2'd1;
				ttw_pkg::BkNum: begin
					ph_q <= (ph_q == 2'd1) ? 2'd0 : 2'd1;
					bit_q <= 7'(QW - 1);
				end
				ttw_pkg::BkDiv: if (bit_q != 7'd0) bit_q <= bit_q - 7'd1;
				ttw_pkg::BkSat: begin
					if (big) flag_q <= 1'b1;
					comp_q <= comp_q + 2'd1;
				end
				ttw_pkg::BkEmit: if (wr.ready) wr_q <= (wr_q == 2'd2) ? 2'd0 : wr_q + 2'd1;
				default: ;
			endcase
		end
	end

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.valid && !wr.ready) |=> wr.valid && wr_q == $past(wr_q))
		else $error("write dropped");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n) wr_q != 2'd3)
		else $error("write count out of range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ttw_pkg::BkIdle) |-> !job_ready) else $error("ready while busy");
endmodule
`default_nettype wire

// ----- rtl/triangle_tangent_writer.sv -----
`default_nettype none
// Channel   Role   Item
// corner    sink   one triangle corner: start_req, vertex_index, position, texcoord
// write     source one tangent write: target_index, tangent xyz, saturated, last_write
// cfg       sink   register write: index 0 det_epsilon, 1 fallback_scale
//
// The first two corners of a triangle are accepted without stall. The third
// corner is placed in a two-entry queue; when the determinant is invertible the
// back end then takes the job, forms the determinant, and per component forms
// the products and the numerator, runs 82 steps of the shared restoring divider
// and saturates the result, then makes three writes. When the determinant is too
// small no component steps the divider; the numerator is scaled by fallback_scale
// instead. Write stalls hold the back end in its write state. The divider sets the rate.
// Reset is asynchronous, active low, and clears counters and held corners.
// The write channel may stall at will; the queue lets corners keep arriving until it is full.
module triangle_tangent_writer (
	input wire logic clk,
	input wire logic arst_n,
	ttw_corner_if.sink corner,
	ttw_write_if.source write,
	ttw_cfg_if.sink cfg
);
	logic [ttw_pkg::EpsWidth-1:0] det_epsilon_q;
	logic [ttw_pkg::ScaleWidth-1:0] fallback_scale_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	ttw_pkg::tri_job_t fj, bj;

	// Configuration is always accepted; out-of-range indexes cannot occur.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_epsilon_q <= ttw_pkg::EpsReset;
			fallback_scale_q <= ttw_pkg::ScaleReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				ttw_pkg::RegDetEpsilon: det_epsilon_q <= cfg.data;
				ttw_pkg::RegFallbackScale: fallback_scale_q <= cfg.data[ttw_pkg::ScaleWidth-1:0];
				default: ;
			endcase
		end
	end

	ttw_front u_front (.clk, .arst_n, .corner, .job_valid(fj_valid), .job_ready(fj_ready),
		.job(fj));

	ttw_queue u_queue (.clk, .arst_n, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
		.out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj));

	ttw_back u_back (.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.det_epsilon(det_epsilon_q), .fallback_scale(fallback_scale_q), .wr(write));
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	// One expected tangent write, as the block should put it on the write channel.
	typedef struct {
		logic [ttw_pkg::IndexWidth-1:0] target_index;
		logic [ttw_pkg::TanWidth-1:0] tangent_x;
		logic [ttw_pkg::TanWidth-1:0] tangent_y;
		logic [ttw_pkg::TanWidth-1:0] tangent_z;
		logic saturated;
		logic last_write;
	} tangent_write_t;

	localparam int unsigned CycleLimit = 400000;
	// The back end can hold one triangle while two more are queued.
	localparam int unsigned DrainCycles = 400;

	logic clk;
	logic arst_n;

	ttw_corner_if corner_bus ();
	ttw_write_if write_bus ();
	ttw_cfg_if cfg_bus ();

	triangle_tangent_writer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.corner(corner_bus.sink),
		.write(write_bus.source),
		.cfg(cfg_bus.sink)
	);

	// Predictor state: register copies and the held corners of the open triangle.
	logic [ttw_pkg::EpsWidth-1:0] epsilon_reg;
	logic [ttw_pkg::ScaleWidth-1:0] scale_reg;
	int unsigned corner_slot;
	logic [ttw_pkg::IndexWidth-1:0] kept_index[2];
	logic signed [ttw_pkg::CoordWidth-1:0] kept_pos[6];
	logic signed [ttw_pkg::CoordWidth-1:0] kept_uv[4];

	tangent_write_t pending_writes[$];

	int unsigned error_count;
	int unsigned corners_sent;
	int unsigned writes_seen;
	int unsigned triangles_saturated;
	int unsigned triangles_fallback;
	longint unsigned cycle_count;

	// Receiver behavior, steered by the test tasks.
	bit write_idling;
	int unsigned hold_off_cycles;
	bit sender_idling;

	// Clock and watchdog.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("Timeout after %0d cycles with %0d writes still expected.",
					cycle_count, pending_writes.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// One tangent component: the numerator dV2*E1 - dV1*E2 is exact, then either divided
	// by the determinant or scaled by the fallback factor, and finally clipped to 48 bits.
	// The top bit of the return value is the clip flag.
	function automatic logic [ttw_pkg::TanWidth:0] tangent_component(input longint e1,
			input longint e2, input longint dv1, input longint dv2, input bit use_inverse,
			input bit det_negative, input logic [63:0] det_magnitude);
		logic signed [127:0] a, b, c, d, numer;
		logic [127:0] magnitude, quotient, limit;
		bit negative;
		bit clipped;
		a = dv2;
		b = e1;
		c = dv1;
		d = e2;
		numer = a * b - c * d;
		negative = numer[127];
		magnitude = negative ? -numer : numer;
		if (use_inverse) begin
			quotient = (magnitude << 16) / {64'd0, det_magnitude};
			negative = negative ^ det_negative;
		end else begin
			quotient = (magnitude * {108'd0, scale_reg}) >> 16;
		end
		if (quotient == 0)
			negative = 1'b0;
		limit = negative ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
		clipped = quotient > limit;
		if (clipped)
			quotient = limit;
		if (negative)
			quotient = -quotient;
		return {clipped, quotient[ttw_pkg::TanWidth-1:0]};
	endfunction

	// Advances the predictor by one accepted corner and queues the writes it causes.
	task automatic predict_corner(input logic start, input logic [ttw_pkg::IndexWidth-1:0] vidx,
			input logic signed [ttw_pkg::CoordWidth-1:0] px,
			input logic signed [ttw_pkg::CoordWidth-1:0] py,
			input logic signed [ttw_pkg::CoordWidth-1:0] pz,
			input logic signed [ttw_pkg::CoordWidth-1:0] tu,
			input logic signed [ttw_pkg::CoordWidth-1:0] tv);
		longint du1, dv1, du2, dv2;
		logic signed [ttw_pkg::CoordWidth-1:0] here[3];
		logic signed [127:0] p1, p2, q1, q2, det;
		logic [127:0] det_abs;
		logic [63:0] det_magnitude;
		bit det_negative, use_inverse, clip_any;
		logic [ttw_pkg::TanWidth:0] comp;
		logic [ttw_pkg::TanWidth-1:0] tan[3];
		logic [ttw_pkg::IndexWidth-1:0] order[3];
		tangent_write_t w;
		here[0] = px;
		here[1] = py;
		here[2] = pz;
		if (start)
			corner_slot = 0;
		if (corner_slot < 2) begin
			kept_index[corner_slot] = vidx;
			for (int k = 0; k < 3; k++)
				kept_pos[corner_slot * 3 + k] = here[k];
			kept_uv[corner_slot * 2] = tu;
			kept_uv[corner_slot * 2 + 1] = tv;
			corner_slot++;
			return;
		end
		corner_slot = 0;
		du1 = longint'(kept_uv[2]) - longint'(kept_uv[0]);
		dv1 = longint'(kept_uv[3]) - longint'(kept_uv[1]);
		du2 = longint'(tu) - longint'(kept_uv[0]);
		dv2 = longint'(tv) - longint'(kept_uv[1]);
		p1 = du1;
		p2 = dv2;
		q1 = du2;
		q2 = dv1;
		det = p1 * p2 - q1 * q2;
		det_negative = det[127];
		// The determinant is clipped to signed 64 bits before its magnitude is taken.
		if (!det_negative) begin
			det_abs = det;
			det_magnitude = (det_abs > 128'h7FFF_FFFF_FFFF_FFFF) ?
				64'h7FFF_FFFF_FFFF_FFFF : det_abs[63:0];
		end else begin
			det_abs = -det;
			det_magnitude = (det_abs > 128'h8000_0000_0000_0000) ?
				64'h8000_0000_0000_0000 : det_abs[63:0];
		end
		use_inverse = det_magnitude > {32'd0, epsilon_reg};
		if (!use_inverse)
			triangles_fallback++;
		clip_any = 1'b0;
		for (int k = 0; k < 3; k++) begin
			comp = tangent_component(longint'(kept_pos[3 + k]) - longint'(kept_pos[k]),
				longint'(here[k]) - longint'(kept_pos[k]), dv1, dv2, use_inverse,
				det_negative, det_magnitude);
			clip_any |= comp[ttw_pkg::TanWidth];
			tan[k] = comp[ttw_pkg::TanWidth-1:0];
		end
		// A tangent that comes out all zero is replaced by the unit x axis.
		if (tan[0] == 0 && tan[1] == 0 && tan[2] == 0) begin
			tan[0] = ttw_pkg::UnitTangent;
			clip_any = 1'b0;
		end
		if (clip_any)
			triangles_saturated++;
		order[0] = kept_index[0];
		order[1] = kept_index[1];
		order[2] = vidx;
		for (int r = 0; r < 3; r++) begin
			w.target_index = order[r];
			w.tangent_x = tan[0];
			w.tangent_y = tan[1];
			w.tangent_z = tan[2];
			w.saturated = clip_any;
			w.last_write = (r == 2);
			pending_writes = {pending_writes, w};
		end
	endtask

	// Compares every accepted write with the oldest expected one.
	initial begin
		tangent_write_t w;
		writes_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && write_bus.valid && write_bus.ready) begin
				writes_seen++;
				if (pending_writes.size() == 0) begin
					$error("Unexpected write to vertex %0d.", write_bus.target_index);
					error_count++;
				end else begin
					w = pending_writes.pop_front();
					if (write_bus.target_index !== w.target_index) begin
						$error("target_index: expected %0d, got %0d", w.target_index,
							write_bus.target_index);
						error_count++;
					end
					if (write_bus.tangent_x !== w.tangent_x) begin
						$error("tangent_x: expected %h, got %h", w.tangent_x,
							write_bus.tangent_x);
						error_count++;
					end
					if (write_bus.tangent_y !== w.tangent_y) begin
						$error("tangent_y: expected %h, got %h", w.tangent_y,
							write_bus.tangent_y);
						error_count++;
					end
					if (write_bus.tangent_z !== w.tangent_z) begin
						$error("tangent_z: expected %h, got %h", w.tangent_z,
							write_bus.tangent_z);
						error_count++;
					end
					if (write_bus.saturated !== w.saturated) begin
						$error("saturated: expected %b, got %b", w.saturated,
							write_bus.saturated);
						error_count++;
					end
					if (write_bus.last_write !== w.last_write) begin
						$error("last_write: expected %b, got %b", w.last_write,
							write_bus.last_write);
						error_count++;
					end
				end
			end
		end
	end

	// Drives ready on the write channel. A requested hold-off takes precedence;
	// otherwise ready drops in random bursts while idling is enabled.
	initial begin
		int unsigned burst;
		burst = 0;
		write_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				write_bus.ready = 1'b0;
				hold_off_cycles--;
			end else if (burst > 0) begin
				write_bus.ready = 1'b0;
				burst--;
			end else if (write_idling && $urandom_range(0, 5) == 0) begin
				write_bus.ready = 1'b0;
				burst = $urandom_range(0, 14);
			end else begin
				write_bus.ready = 1'b1;
			end
		end
	end

	// Offers one corner, optionally after a random idle burst, and returns at the
	// falling edge after it was accepted. Valid stays high for the next call.
	task automatic send_corner(input logic start, input logic [ttw_pkg::IndexWidth-1:0] vidx,
			input logic signed [ttw_pkg::CoordWidth-1:0] px,
			input logic signed [ttw_pkg::CoordWidth-1:0] py,
			input logic signed [ttw_pkg::CoordWidth-1:0] pz,
			input logic signed [ttw_pkg::CoordWidth-1:0] tu,
			input logic signed [ttw_pkg::CoordWidth-1:0] tv);
		if (sender_idling && $urandom_range(0, 4) == 0) begin
			corner_bus.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		corner_bus.start_req = start;
		corner_bus.vertex_index = vidx;
		corner_bus.pos_x = px;
		corner_bus.pos_y = py;
		corner_bus.pos_z = pz;
		corner_bus.tex_u = tu;
		corner_bus.tex_v = tv;
		corner_bus.valid = 1'b1;
		do
			@(posedge clk);
		while (!corner_bus.ready);
		predict_corner(start, vidx, px, py, pz, tu, tv);
		corners_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected write has arrived and the back end has gone quiet.
	task automatic wait_idle();
		corner_bus.valid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_register(input logic [ttw_pkg::CfgIdxWidth-1:0] index,
			input logic [31:0] data);
		cfg_bus.index = index;
		cfg_bus.data = data;
		cfg_bus.valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		if (index == ttw_pkg::RegDetEpsilon)
			epsilon_reg = data;
		else
			scale_reg = data[ttw_pkg::ScaleWidth-1:0];
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic configure(input logic [31:0] epsilon, input logic [31:0] scale);
		wait_idle();
		write_register(ttw_pkg::RegDetEpsilon, epsilon);
		write_register(ttw_pkg::RegFallbackScale, scale);
	endtask

	function automatic logic [31:0] random_coord(input int unsigned spread);
		case ($urandom_range(0, 3))
			0: return $urandom;
			default: return $urandom_range(0, 2 * spread) - spread;
		endcase
	endfunction

	// A well-formed triangle with random content. The spread picks between small
	// coordinates that give ordinary tangents and wide ones that stress clipping.
	task automatic send_random_triangle();
		int unsigned spread;
		spread = $urandom_range(0, 1) ? 32'h0004_0000 : 32'h4000_0000;
		for (int c = 0; c < 3; c++)
			send_corner(c == 0, (ttw_pkg::IndexWidth)'($urandom), random_coord(spread),
				random_coord(spread), random_coord(spread), random_coord(spread),
				random_coord(spread));
	endtask

	// Directed triangles: a plain one, degenerate texture coordinates that fall back
	// to the scale factor and become the unit tangent, a restart in mid-triangle,
	// field extremes, a mirrored map with a negative determinant, and clipping.
	task automatic test_directed();
		send_corner(1'b1, 16'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
		send_corner(1'b0, 16'd1, 32'sh1_0000, 32'sh0, 32'sh0, 32'sh1_0000, 32'sh0);
		send_corner(1'b0, 16'hFFFF, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh0, 32'sh1_0000);
		// All texture coordinates equal: the determinant is zero.
		send_corner(1'b1, 16'd10, 32'sh0, 32'sh0, 32'sh0, 32'sh5000, 32'sh5000);
		send_corner(1'b0, 16'd11, 32'sh0, 32'sh0, 32'sh0, 32'sh5000, 32'sh5000);
		send_corner(1'b0, 16'd12, 32'sh0, 32'sh0, 32'sh0, 32'sh5000, 32'sh5000);
		// Restart on the second corner, so only the last three corners form a triangle.
		send_corner(1'b1, 16'd20, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
		send_corner(1'b1, 16'd21, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
		send_corner(1'b0, 16'd22, 32'sh3_0000, 32'sh2_0000, 32'sh1_0000, 32'sh0, 32'sh2_0000);
		send_corner(1'b0, 16'd23, 32'sh1_0000, 32'sh5_0000, 32'sh7_0000, 32'sh3_0000, 32'sh0);
		// Extremes of every coordinate with a mirrored map.
		send_corner(1'b1, 16'h8000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000);
		send_corner(1'b0, 16'h7FFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF);
		send_corner(1'b0, 16'h00FF, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		// A determinant just above the threshold with long edges clips every component.
		send_corner(1'b1, 16'd30, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh0, 32'sh0);
		send_corner(1'b0, 16'd31, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 32'sh1, 32'sh0);
		send_corner(1'b0, 16'd32, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh400);
		// A degenerate map with long edges clips through the fallback factor.
		send_corner(1'b1, 16'd40, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
		send_corner(1'b0, 16'd41, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh10);
		send_corner(1'b0, 16'd42, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
			32'sh7FFF_FFFF);
	endtask

	// Runs triangles under each extreme of both registers.
	task automatic test_register_extremes();
		configure(32'd0, 32'd0);
		repeat (4) send_random_triangle();
		configure(32'hFFFF_FFFF, 32'h000F_FFFF);
		repeat (4) send_random_triangle();
		configure(32'h0000_0001, 32'd1);
		repeat (4) send_random_triangle();
		configure(32'h8000_0000, 32'h000A_5A5A);
		repeat (4) send_random_triangle();
	endtask

	// Mostly well-formed triangles, with some stray restarts and unaligned corners.
	task automatic test_random(input int unsigned corner_budget);
		int unsigned stop_at;
		stop_at = corners_sent + corner_budget;
		while (corners_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				send_corner(1'($urandom_range(0, 1)), (ttw_pkg::IndexWidth)'($urandom),
					$urandom, $urandom, $urandom, $urandom, $urandom);
			else
				send_random_triangle();
		end
	endtask

	// The write side holds off for a long stretch while corners keep coming, so the
	// block's queue fills and it has to stall the corner channel.
	task automatic test_back_pressure();
		wait_idle();
		@(negedge clk);
		hold_off_cycles = 600;
		repeat (6) send_random_triangle();
	endtask

	initial begin
		error_count = 0;
		corners_sent = 0;
		triangles_saturated = 0;
		triangles_fallback = 0;
		hold_off_cycles = 0;
		write_idling = 1'b1;
		sender_idling = 1'b1;
		epsilon_reg = ttw_pkg::EpsReset;
		scale_reg = ttw_pkg::ScaleReset;
		corner_slot = 0;
		for (int k = 0; k < 2; k++)
			kept_index[k] = '0;
		for (int k = 0; k < 6; k++)
			kept_pos[k] = '0;
		for (int k = 0; k < 4; k++)
			kept_uv[k] = '0;
		corner_bus.valid = 1'b0;
		corner_bus.start_req = 1'b0;
		corner_bus.vertex_index = '0;
		corner_bus.pos_x = '0;
		corner_bus.pos_y = '0;
		corner_bus.pos_z = '0;
		corner_bus.tex_u = '0;
		corner_bus.tex_v = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = ttw_pkg::RegDetEpsilon;
		cfg_bus.data = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_register_extremes();
		configure(32'd512, 32'd100000);
		test_random(70);
		test_back_pressure();
		configure(32'h0001_0000, 32'h0000_3000);
		test_random(60);
		// The final stretch runs with both sides always willing.
		write_idling = 1'b0;
		sender_idling = 1'b0;
		test_random(45);

		wait_idle();
		$display("Sent %0d corners and checked %0d tangent writes.", corners_sent, writes_seen);
		$display("Triangles on the fallback factor: %0d, with clipped tangents: %0d.",
			triangles_fallback, triangles_saturated);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
